// File: design/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, widths, status codes and the size-class table of the
// size-class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

   localparam int DEF_NUM_CLASSES = 16;
   localparam int DEF_SLOTS       = 4096;

   localparam int CHUNK_W     = 21;
   localparam int SIZE_W      = 32;
   localparam int CLASS_W     = 4;
   localparam int SLOT_IO_W   = 12;
   localparam int STATUS_W    = 3;
   localparam int BYTES_W     = 14;
   localparam int USED_TOT_W  = 27;
   localparam int CHUNK_TOT_W = 17;
   localparam int ACC_W       = 22;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CHUNK_W-1:0]    DEFAULT_CHUNK = CHUNK_W'(65536);
   localparam logic [CSR_ADDR_W-1:0] REG_CHUNK_BYTES = '0;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK           = 3'd0,
      STAT_TOO_LARGE    = 3'd1,
      STAT_OUT_OF_SPACE = 3'd2,
      STAT_NOT_OWNED    = 3'd3,
      STAT_DOUBLE_FREE  = 3'd4
   } stat_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CARVE,
      S_POP_RD,
      S_POP_DATA,
      S_FREE_RD,
      S_FREE_CHK,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic     load_req;
      logic     carve_start;
      logic     carve_step;
      logic     pop_rd;
      logic     pop_fin;
      logic     free_rd;
      logic     free_push;
      logic     set_status;
      stat_type status;
      logic     load_rsp;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic too_large;
      logic stack_empty;
      logic class_full;
      logic unowned;
      logic carve_last;
      logic slot_free;
      logic rsp_busy;
   } sts_type;

   function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
      logic [BYTES_W-1:0] b;
      case (c)
         4'd0:    b = 14'd16;
         4'd1:    b = 14'd32;
         4'd2:    b = 14'd48;
         4'd3:    b = 14'd64;
         4'd4:    b = 14'd96;
         4'd5:    b = 14'd128;
         4'd6:    b = 14'd192;
         4'd7:    b = 14'd256;
         4'd8:    b = 14'd384;
         4'd9:    b = 14'd512;
         4'd10:   b = 14'd768;
         4'd11:   b = 14'd1024;
         4'd12:   b = 14'd1536;
         4'd13:   b = 14'd2048;
         4'd14:   b = 14'd4096;
         default: b = 14'd8192;
      endcase
      return b;
   endfunction

endpackage

// File: design/size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Segregated free-list block allocator with fixed size classes.
// ----------------------------------------------------------------------------
// Sequence: a too-large, out-of-space or unowned request goes from decode to result;
//   a pop passes pop read and pop data, a push or a double free passes free read and
//   free check; a chunk carve, one slot per cycle, first refills an empty class stack.
// Throughput: one item at a time; the next item can be accepted once the result is
//   in the output register; the result state holds while the previous result is not taken.
// Reset: synchronous; clears all class counters and totals, no RAM sweep.
module size_class_block_allocator
   import scba_pkg::*;
#(
   parameter int NUM_CLASSES     = DEF_NUM_CLASSES,
   parameter int SLOTS_PER_CLASS = DEF_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_func,
   input  logic [SIZE_W-1:0]      req_size,
   input  logic [CLASS_W-1:0]     req_free_class,
   input  logic [SLOT_IO_W-1:0]   req_free_slot,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [CLASS_W-1:0]     rsp_class_index,
   output logic [SLOT_IO_W-1:0]   rsp_slot_index,
   output logic [BYTES_W-1:0]     rsp_block_bytes,
   output logic [USED_TOT_W-1:0]  rsp_used_bytes_total,
   output logic [CHUNK_TOT_W-1:0] rsp_chunk_count_total,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [CHUNK_W-1:0] chunk_ff;
   logic [CHUNK_W-1:0] chunk_eff;
   cmd_type            cmd;
   sts_type            sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= DEFAULT_CHUNK;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_CHUNK_BYTES) begin
         chunk_ff <= csr_pwdata[CHUNK_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_CHUNK_BYTES) ? CSR_DATA_W'(chunk_ff) : '0;
   assign chunk_eff  = (chunk_ff == '0) ? DEFAULT_CHUNK : chunk_ff;

   scba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   scba_dp #(
      .NUM_CLASSES     (NUM_CLASSES),
      .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .chunk_eff             (chunk_eff),
      .req_func              (req_func),
      .req_size              (req_size),
      .req_free_class        (req_free_class),
      .req_free_slot         (req_free_slot),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_class_index       (rsp_class_index),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_block_bytes       (rsp_block_bytes),
      .rsp_used_bytes_total  (rsp_used_bytes_total),
      .rsp_chunk_count_total (rsp_chunk_count_total)
   );

endmodule

// File: design/scba_ram.sv
// ----------------------------------------------------------------------------
// scba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/scba_ctrl.sv
// ----------------------------------------------------------------------------
// scba_ctrl
// Sequencer of the allocator: decode, carve, pop, push and result hand-off.
// ----------------------------------------------------------------------------
module scba_ctrl
   import scba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (!sts.func) begin
               if (sts.too_large) state_in = S_RESULT;
               else if (sts.stack_empty) state_in = sts.class_full ? S_RESULT : S_CARVE;
               else state_in = S_POP_RD;
            end else begin
               state_in = sts.unowned ? S_RESULT : S_FREE_RD;
            end
         end
         S_CARVE: begin
            if (sts.carve_last) state_in = S_POP_RD;
         end
         S_POP_RD:   state_in = S_POP_DATA;
         S_POP_DATA: state_in = S_RESULT;
         S_FREE_RD:  state_in = S_FREE_CHK;
         S_FREE_CHK: state_in = S_RESULT;
         S_RESULT: begin
            if (!sts.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status = STAT_OK;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load_req = req_valid;
         end
         S_DECODE: begin
            if (!sts.func) begin
               if (sts.too_large) begin
                  cmd.set_status = 1'b1;
                  cmd.status = STAT_TOO_LARGE;
               end else if (sts.stack_empty) begin
                  if (sts.class_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status = STAT_OUT_OF_SPACE;
                  end else begin
                     cmd.carve_start = 1'b1;
                  end
               end
            end else if (sts.unowned) begin
               cmd.set_status = 1'b1;
               cmd.status = STAT_NOT_OWNED;
            end
         end
         S_CARVE:  cmd.carve_step = 1'b1;
         S_POP_RD: cmd.pop_rd = 1'b1;
         S_POP_DATA: begin
            cmd.pop_fin = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status = STAT_OK;
         end
         S_FREE_RD: cmd.free_rd = 1'b1;
         S_FREE_CHK: begin
            cmd.set_status = 1'b1;
            if (sts.slot_free) begin
               cmd.status = STAT_DOUBLE_FREE;
            end else begin
               cmd.free_push = 1'b1;
               cmd.status = STAT_OK;
            end
         end
         S_RESULT: cmd.load_rsp = !sts.rsp_busy;
         default: ;
      endcase
   end

endmodule

// File: design/scba_dp.sv
// ----------------------------------------------------------------------------
// scba_dp
// Allocator datapath: per-class counters, free-stack and free-flag RAMs,
// chunk carving counter, running totals and the result register.
// ----------------------------------------------------------------------------
module scba_dp
   import scba_pkg::*;
#(
   parameter int NUM_CLASSES     = DEF_NUM_CLASSES,
   parameter int SLOTS_PER_CLASS = DEF_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic [CHUNK_W-1:0]     chunk_eff,
   input  logic                   req_func,
   input  logic [SIZE_W-1:0]      req_size,
   input  logic [CLASS_W-1:0]     req_free_class,
   input  logic [SLOT_IO_W-1:0]   req_free_slot,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [CLASS_W-1:0]     rsp_class_index,
   output logic [SLOT_IO_W-1:0]   rsp_slot_index,
   output logic [BYTES_W-1:0]     rsp_block_bytes,
   output logic [USED_TOT_W-1:0]  rsp_used_bytes_total,
   output logic [CHUNK_TOT_W-1:0] rsp_chunk_count_total
);

   localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int SLOT_W = $clog2(SLOTS_PER_CLASS);
   localparam int TOP_W  = $clog2(SLOTS_PER_CLASS + 1);
   localparam int DEPTH  = NUM_CLASSES * SLOTS_PER_CLASS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int USED_W = $clog2(SLOTS_PER_CLASS * 8192 + 1);
   localparam int CMP_W  = ACC_W + 1;

   logic                   func_ff;
   logic                   too_large_ff;
   logic [CLASS_W-1:0]     cls_ff;
   logic [SLOT_IO_W-1:0]   slot_ff;
   stat_type               status_ff;
   logic [TOP_W-1:0]       top_ff    [NUM_CLASSES];
   logic [TOP_W-1:0]       carved_ff [NUM_CLASSES];
   logic [USED_W-1:0]      used_ff   [NUM_CLASSES];
   logic [TOP_W-1:0]       cnt_ff;
   logic [ACC_W-1:0]       acc_ff;
   logic [USED_TOT_W-1:0]  used_tot_ff;
   logic [CHUNK_TOT_W-1:0] chunk_tot_ff;
   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [CLASS_W-1:0]     rsp_class_ff;
   logic [SLOT_IO_W-1:0]   rsp_slot_ff;
   logic [BYTES_W-1:0]     rsp_bytes_ff;
   logic [USED_TOT_W-1:0]  rsp_used_ff;
   logic [CHUNK_TOT_W-1:0] rsp_chunk_ff;

   logic [CLASS_W-1:0]  map_cls;
   logic                map_found;
   logic [CLS_W-1:0]    cls_ix;
   logic [BYTES_W-1:0]  block;
   logic [TOP_W-1:0]    top_cur;
   logic [TOP_W-1:0]    carved_cur;
   logic [USED_W-1:0]   used_cur;
   logic [TOP_W-1:0]    new_slot;
   logic [USED_W-1:0]   dec;

   logic              stk_we, stk_re;
   logic [ADDR_W-1:0] stk_waddr, stk_raddr;
   logic [SLOT_W-1:0] stk_wdata, stk_rdata;
   logic              flg_we, flg_re;
   logic [ADDR_W-1:0] flg_waddr, flg_raddr;
   logic              flg_wdata, flg_rdata;

   function automatic logic [ADDR_W-1:0] mem_addr(input logic [CLS_W-1:0] c,
                                                  input logic [TOP_W-1:0] i);
      return ADDR_W'(c) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(i);
   endfunction

   always_comb begin
      map_cls = '0;
      map_found = 1'b0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (req_size <= SIZE_W'(class_bytes(CLASS_W'(c)))) begin
            map_cls = CLASS_W'(c);
            map_found = 1'b1;
         end
      end
   end

   assign cls_ix     = cls_ff[CLS_W-1:0];
   assign block      = class_bytes(cls_ff);
   assign top_cur    = top_ff[cls_ix];
   assign carved_cur = carved_ff[cls_ix];
   assign used_cur   = used_ff[cls_ix];
   assign new_slot   = carved_cur + cnt_ff;
   assign dec        = (used_cur >= USED_W'(block)) ? USED_W'(block) : used_cur;

   always_comb begin
      sts.func        = func_ff;
      sts.too_large   = too_large_ff;
      sts.stack_empty = (top_cur == '0);
      sts.class_full  = (carved_cur == TOP_W'(SLOTS_PER_CLASS));
      sts.unowned     = (CMP_W'(cls_ff) >= CMP_W'(NUM_CLASSES))
                     || (CMP_W'(slot_ff) >= CMP_W'(SLOTS_PER_CLASS))
                     || (CMP_W'(slot_ff) >= CMP_W'(carved_cur));
      sts.carve_last  = (CMP_W'(new_slot) + CMP_W'(1) == CMP_W'(SLOTS_PER_CLASS))
                     || (CMP_W'(acc_ff) + CMP_W'(block) > CMP_W'(chunk_eff));
      sts.slot_free   = flg_rdata;
      sts.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      stk_we    = 1'b0;
      stk_waddr = mem_addr(cls_ix, cnt_ff);
      stk_wdata = SLOT_W'(new_slot);
      if (cmd.carve_step) begin
         stk_we = 1'b1;
      end else if (cmd.free_push) begin
         stk_we    = 1'b1;
         stk_waddr = mem_addr(cls_ix, top_cur);
         stk_wdata = SLOT_W'(slot_ff);
      end
      stk_re    = cmd.pop_rd;
      stk_raddr = mem_addr(cls_ix, top_cur - TOP_W'(1));

      flg_we    = cmd.carve_step || cmd.pop_fin || cmd.free_push;
      flg_waddr = mem_addr(cls_ix, new_slot);
      flg_wdata = 1'b1;
      if (cmd.pop_fin) begin
         flg_waddr = mem_addr(cls_ix, TOP_W'(stk_rdata));
         flg_wdata = 1'b0;
      end else if (cmd.free_push) begin
         flg_waddr = mem_addr(cls_ix, TOP_W'(slot_ff));
      end
      flg_re    = cmd.free_rd;
      flg_raddr = mem_addr(cls_ix, TOP_W'(slot_ff));
   end

   scba_ram #(.WIDTH(SLOT_W), .DEPTH(DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   scba_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flg_we),
      .wr_addr (flg_waddr),
      .wr_data (flg_wdata),
      .rd_en   (flg_re),
      .rd_addr (flg_raddr),
      .rd_data (flg_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff      <= req_func;
         too_large_ff <= !req_func && !map_found;
         cls_ff       <= req_func ? req_free_class : map_cls;
         slot_ff      <= req_func ? req_free_slot : '0;
      end else if (cmd.pop_fin) begin
         slot_ff <= SLOT_IO_W'(stk_rdata);
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.carve_start) begin
         cnt_ff <= '0;
         acc_ff <= ACC_W'(block);
      end else if (cmd.carve_step) begin
         cnt_ff <= cnt_ff + TOP_W'(1);
         acc_ff <= acc_ff + ACC_W'(block);
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_class_ff  <= (status_ff == STAT_TOO_LARGE) ? '0 : cls_ff;
         rsp_slot_ff   <= (status_ff == STAT_TOO_LARGE || status_ff == STAT_OUT_OF_SPACE)
                          ? '0 : slot_ff;
         rsp_bytes_ff  <= (status_ff == STAT_TOO_LARGE || status_ff == STAT_NOT_OWNED)
                          ? '0 : block;
         rsp_used_ff   <= used_tot_ff;
         rsp_chunk_ff  <= chunk_tot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            top_ff[c]    <= '0;
            carved_ff[c] <= '0;
            used_ff[c]   <= '0;
         end
         used_tot_ff  <= '0;
         chunk_tot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.carve_step && sts.carve_last) begin
            top_ff[cls_ix]    <= cnt_ff + TOP_W'(1);
            carved_ff[cls_ix] <= new_slot + TOP_W'(1);
            chunk_tot_ff      <= chunk_tot_ff + CHUNK_TOT_W'(1);
         end
         if (cmd.pop_rd) begin
            top_ff[cls_ix] <= top_cur - TOP_W'(1);
         end
         if (cmd.pop_fin) begin
            used_ff[cls_ix] <= used_cur + USED_W'(block);
            used_tot_ff     <= used_tot_ff + USED_TOT_W'(block);
         end
         if (cmd.free_push) begin
            top_ff[cls_ix]  <= top_cur + TOP_W'(1);
            used_ff[cls_ix] <= used_cur - dec;
            used_tot_ff     <= used_tot_ff - USED_TOT_W'(dec);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_class_index       = rsp_class_ff;
   assign rsp_slot_index        = rsp_slot_ff;
   assign rsp_block_bytes       = rsp_bytes_ff;
   assign rsp_used_bytes_total  = rsp_used_ff;
   assign rsp_chunk_count_total = rsp_chunk_ff;

endmodule

// File: design/scba_checker.sv
// ----------------------------------------------------------------------------
// scba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module scba_checker
   import scba_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [CLASS_W-1:0]    rsp_class_index,
   input logic [SLOT_IO_W-1:0]  rsp_slot_index,
   input logic [BYTES_W-1:0]    rsp_block_bytes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before accept");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while busy");

   a_too_large: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_TOO_LARGE |->
         rsp_block_bytes == '0 && rsp_class_index == '0 && rsp_slot_index == '0)
      else $error("too-large result carries a block");

   a_not_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_NOT_OWNED |-> rsp_block_bytes == '0)
      else $error("unowned handle reports a block size");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STAT_DOUBLE_FREE)
      else $error("undefined status code");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (.*);
